// ----- hw/rtl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Clocked assertion shorthands used by the top-level RTL file of the triac controller.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

// ----- hw/rtl/tpac_pkg.sv -----
// ============================================================================
// Triac phase-angle controller package
// Shared types, operation codes and constants of the controller and datapath.
// ============================================================================
`default_nettype none

package tpac_pkg;

    localparam int DEF_SAMPLES_PER_AVERAGE = 200;
    localparam int DEF_PRESCALE_TICKS      = 128;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_ZERO_CROSS  = 2'd1;
    localparam logic [1:0] OP_SAMPLE      = 2'd2;
    localparam logic [1:0] OP_TEMPERATURE = 2'd3;

    localparam logic [1:0] MAINS_UNKNOWN = 2'd0;
    localparam logic [1:0] MAINS_50HZ    = 2'd1;
    localparam logic [1:0] MAINS_60HZ    = 2'd2;

    localparam logic [0:0] REG_SCALING = 1'b0;

    // Division of the sample sum by reciprocal multiplication.
    localparam int DIV_SHIFT = 24;
    localparam int DIV_MUL_W = 25;
    localparam int DIV_PROD_W = 16 + DIV_MUL_W;

    // avg * 151 / 100 done as one multiplication and a shift (exact for avg <= 168).
    localparam logic [22:0] SCALE_MUL   = 23'd6333544;
    localparam int          SCALE_SHIFT = 22;
    localparam logic [7:0]  SCALE_CLAMP = 8'd168;

    localparam logic [7:0] LEVEL_OFF = 8'd235;
    localparam logic [7:0] LEVEL_MIN = 8'd15;

    localparam logic [6:0] HPU_50HZ = 7'd100;
    localparam logic [6:0] HPU_60HZ = 7'd83;

    localparam logic [7:0] PERIOD_50_LO = 8'd150;
    localparam logic [7:0] PERIOD_50_HI = 8'd162;
    localparam logic [7:0] PERIOD_60_LO = 8'd123;
    localparam logic [7:0] PERIOD_60_HI = 8'd135;

    localparam logic [7:0]  PRELOAD_STEP   = 8'd200;
    localparam logic [15:0] PULSE_OFFSET   = 16'd1000;
    localparam logic [15:0] TIMER_RESET    = 16'h0055;
    localparam logic [1:0]  PHASE_LAST     = 2'd1;

    localparam logic signed [7:0] TEMP_IGNORE      = 8'sd85;
    localparam logic signed [7:0] TEMP_FAN_ON      = 8'sd50;
    localparam logic signed [7:0] TEMP_PROTECT_ON  = 8'sd60;
    localparam logic signed [7:0] TEMP_PROTECT_OFF = 8'sd54;
    localparam logic signed [7:0] TEMP_COOL_MAX    = 8'sd39;
    localparam logic signed [7:0] TEMP_COOL_MIN    = 8'sd1;

    typedef struct packed {
        logic accept;
        logic div;
        logic scale;
        logic level;
        logic pre;
        logic load;
        logic publish;
    } tpac_cmd_t;

    typedef struct packed {
        logic avg_due;
    } tpac_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/triac_phase_angle_controller.sv -----
// ============================================================================
// Triac phase-angle controller
// Phase-angle firing control with mains detection, input averaging and
// temperature-driven fan and overheat protection.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    operation, sample_value, temperature
//   m_       out        m_valid/m_ready    gate, fan, protect, enable, mains, level
//   APB      in         psel/penable       input_scaling_on at address 0
//
// Ticks, zero-cross edges, temperature readings and samples that do not close
// an averaging group are published on acceptance; the result is registered at
// the accept edge. The sample that closes a group runs the five-step division,
// scaling and preload sequence, then the result state, which waits for space.
// A new request is taken while a result waits, as long as the output register
// frees at the same edge. Reset is synchronous and needs no clearing pass.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module triac_phase_angle_controller
    import tpac_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = DEF_SAMPLES_PER_AVERAGE,
    parameter int PRESCALE_TICKS      = DEF_PRESCALE_TICKS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_operation,
    input  wire logic [7:0]            s_sample_value,
    input  wire logic signed [7:0]     s_temperature,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_gate_drive,
    output logic                       m_fan_on,
    output logic                       m_overheat_protect,
    output logic                       m_firing_enabled,
    output logic [1:0]                 m_mains_kind,
    output logic                       m_mains_present,
    output logic [7:0]                 m_level
);

    tpac_cmd_t    cmd;
    tpac_status_t status;
    logic         scaling_reg;
    logic         reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SCALING);
    assign prdata  = reg_hit ? {{(APB_DATA_W - 1){1'b0}}, scaling_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scaling_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            scaling_reg <= pwdata[0];
        end
    end

    tpac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tpac_dp #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .PRESCALE_TICKS      (PRESCALE_TICKS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .scaling_on         (scaling_reg),
        .s_operation        (s_operation),
        .s_sample_value     (s_sample_value),
        .s_temperature      (s_temperature),
        .m_gate_drive       (m_gate_drive),
        .m_fan_on           (m_fan_on),
        .m_overheat_protect (m_overheat_protect),
        .m_firing_enabled   (m_firing_enabled),
        .m_mains_kind       (m_mains_kind),
        .m_mains_present    (m_mains_present),
        .m_level            (m_level)
    );

    `ASSERT_HOLDS(a_div_follows_group, cmd.accept && status.avg_due |=> cmd.div, "closing sample did not start the division")
    `ASSERT_NEVER(a_publish_overrun, cmd.publish && m_valid && !m_ready, "result published over a waiting result")
    `ASSERT_NEVER(a_gate_needs_enable, m_valid && m_gate_drive && !m_firing_enabled, "gate driven while firing disabled")
    `ASSERT_NEVER(a_present_needs_kind, m_valid && m_mains_present && m_mains_kind == MAINS_UNKNOWN, "mains present without a known kind")

endmodule

`default_nettype wire

// ----- hw/rtl/tpac_ctrl.sv -----
// ============================================================================
// Triac controller sequencer
// Accepts requests, steps the averaging datapath and hands results out.
// ============================================================================
`default_nettype none

module tpac_ctrl
    import tpac_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire tpac_status_t status,
    output tpac_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_LEVEL = 3'd3;
    localparam logic [2:0] ST_PRE   = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;
    localparam logic [2:0] ST_PUB   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    cmd.accept = 1'b1;
                    if (status.avg_due) begin
                        state_next = ST_DIV;
                    end else begin
                        cmd.publish = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_LEVEL;
            end
            ST_LEVEL: begin
                cmd.level  = 1'b1;
                state_next = ST_PRE;
            end
            ST_PRE: begin
                cmd.pre    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_PUB;
            end
            ST_PUB: begin
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tpac_dp.sv -----
// ============================================================================
// Triac controller datapath
// Timer, mains detection, sample averaging, preloads, temperature and result.
// ============================================================================
`default_nettype none

module tpac_dp
    import tpac_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = DEF_SAMPLES_PER_AVERAGE,
    parameter int PRESCALE_TICKS      = DEF_PRESCALE_TICKS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tpac_cmd_t         cmd,
    output tpac_status_t           status,
    input  wire logic              scaling_on,
    input  wire logic [1:0]        s_operation,
    input  wire logic [7:0]        s_sample_value,
    input  wire logic signed [7:0] s_temperature,
    output logic                   m_gate_drive,
    output logic                   m_fan_on,
    output logic                   m_overheat_protect,
    output logic                   m_firing_enabled,
    output logic [1:0]             m_mains_kind,
    output logic                   m_mains_present,
    output logic [7:0]             m_level
);

    localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam int PS_W  = (PRESCALE_TICKS > 1) ? $clog2(PRESCALE_TICKS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);
    localparam logic [PS_W:0]    PS_LIMIT = (PS_W + 1)'(PRESCALE_TICKS);
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((2 ** DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    logic [PS_W-1:0]  prescale_reg,  prescale_next;
    logic [7:0]       period_reg,    period_next;
    logic [6:0]       hpu_reg,       hpu_next;
    logic [1:0]       kind_reg,      kind_next;
    logic             present_reg,   present_next;
    logic [15:0]      timer_reg,     timer_next;
    logic             running_reg,   running_next;
    logic [1:0]       phase_reg,     phase_next;
    logic             gate_reg,      gate_next;
    logic [15:0]      sum_reg,       sum_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [7:0]       level_reg,     level_next;
    logic             enable_reg,    enable_next;
    logic [15:0]      delay_pl_reg,  delay_pl_next;
    logic [15:0]      pulse_pl_reg,  pulse_pl_next;
    logic             protect_reg,   protect_next;
    logic             fan_reg,       fan_next;

    logic [DIV_PROD_W-1:0] div_prod_reg;
    logic [7:0]            avg_reg;
    logic [14:0]           lh_reg;
    logic [14:0]           var_reg;
    logic [14:0]           hp200_reg;

    logic                  gate_out_reg;
    logic                  fan_out_reg;
    logic                  protect_out_reg;
    logic                  enable_out_reg;
    logic [1:0]            kind_out_reg;
    logic                  present_out_reg;
    logic [7:0]            level_out_reg;

    logic [15:0] timer_inc;
    logic [PS_W:0] prescale_inc;
    logic [7:0]  avg_raw;
    logic [7:0]  avg_clamped;
    logic [30:0] scale_prod;
    logic [7:0]  level_inv;
    logic [7:0]  level_new;

    assign status.avg_due = (s_operation == OP_SAMPLE) && (count_reg == CNT_LAST);

    assign timer_inc    = timer_reg + 16'd1;
    assign prescale_inc = {1'b0, prescale_reg} + (PS_W + 1)'(1);
    assign avg_raw      = div_prod_reg[DIV_SHIFT +: 8];
    assign avg_clamped  = (avg_raw > SCALE_CLAMP) ? SCALE_CLAMP : avg_raw;
    assign scale_prod   = 31'(avg_clamped) * 31'(SCALE_MUL);
    assign level_inv    = 8'hFF - avg_reg;
    assign level_new    = (level_inv < LEVEL_MIN) ? LEVEL_MIN : level_inv;

    always_comb begin
        prescale_next = prescale_reg;
        period_next   = period_reg;
        hpu_next      = hpu_reg;
        kind_next     = kind_reg;
        present_next  = present_reg;
        timer_next    = timer_reg;
        running_next  = running_reg;
        phase_next    = phase_reg;
        gate_next     = gate_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        level_next    = level_reg;
        enable_next   = enable_reg;
        delay_pl_next = delay_pl_reg;
        pulse_pl_next = pulse_pl_reg;
        protect_next  = protect_reg;
        fan_next      = fan_reg;

        if (cmd.accept) begin
            case (s_operation)
                OP_TICK: begin
                    if (running_reg) begin
                        if (timer_inc == 16'h0000) begin
                            timer_next = pulse_pl_reg;
                            if (phase_reg == PHASE_LAST) begin
                                gate_next    = 1'b0;
                                phase_next   = 2'd0;
                                running_next = 1'b0;
                            end else begin
                                gate_next  = 1'b1;
                                phase_next = phase_reg + 2'd1;
                            end
                        end else begin
                            timer_next = timer_inc;
                        end
                    end
                    if (prescale_inc >= PS_LIMIT) begin
                        prescale_next = '0;
                        period_next   = period_reg + 8'd1;
                        if (period_reg == 8'hFF) begin
                            present_next = 1'b0;
                            running_next = 1'b0;
                        end
                    end else begin
                        prescale_next = prescale_inc[PS_W-1:0];
                    end
                end
                OP_ZERO_CROSS: begin
                    if (enable_reg && !protect_reg) begin
                        timer_next   = delay_pl_reg;
                        running_next = 1'b1;
                    end
                    period_next = 8'd0;
                    if (period_reg >= PERIOD_50_LO && period_reg <= PERIOD_50_HI) begin
                        kind_next    = MAINS_50HZ;
                        present_next = 1'b1;
                        hpu_next     = HPU_50HZ;
                    end
                    if (period_reg >= PERIOD_60_LO && period_reg <= PERIOD_60_HI) begin
                        kind_next    = MAINS_60HZ;
                        present_next = 1'b1;
                        hpu_next     = HPU_60HZ;
                    end
                end
                OP_SAMPLE: begin
                    sum_next   = sum_reg + {8'd0, s_sample_value};
                    count_next = status.avg_due ? '0 : count_reg + CNT_W'(1);
                end
                OP_TEMPERATURE: begin
                    if (s_temperature != TEMP_IGNORE) begin
                        if (s_temperature >= TEMP_FAN_ON) begin
                            fan_next = 1'b1;
                            if (s_temperature >= TEMP_PROTECT_ON) begin
                                protect_next = 1'b1;
                            end else if (s_temperature <= TEMP_PROTECT_OFF) begin
                                protect_next = 1'b0;
                            end
                        end else if (s_temperature <= TEMP_COOL_MAX &&
                                     s_temperature >= TEMP_COOL_MIN) begin
                            fan_next     = 1'b0;
                            protect_next = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.level) begin
            sum_next = 16'd0;
            if (level_inv < LEVEL_OFF) begin
                enable_next = 1'b1;
                level_next  = level_new;
            end else begin
                enable_next  = 1'b0;
                running_next = 1'b0;
                gate_next    = 1'b0;
                level_next   = level_inv;
            end
        end

        if (cmd.load) begin
            delay_pl_next = 16'hFFFF - {1'b0, var_reg};
            pulse_pl_next = 16'hFFFF -
                ({1'b0, hp200_reg} - ({1'b0, var_reg} + PULSE_OFFSET));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            period_reg   <= 8'd0;
            hpu_reg      <= 7'd0;
            kind_reg     <= MAINS_UNKNOWN;
            present_reg  <= 1'b0;
            timer_reg    <= TIMER_RESET;
            running_reg  <= 1'b0;
            phase_reg    <= 2'd0;
            gate_reg     <= 1'b0;
            sum_reg      <= 16'd0;
            count_reg    <= '0;
            level_reg    <= 8'd0;
            enable_reg   <= 1'b0;
            delay_pl_reg <= 16'd0;
            pulse_pl_reg <= 16'd0;
            protect_reg  <= 1'b0;
            fan_reg      <= 1'b0;
        end else begin
            prescale_reg <= prescale_next;
            period_reg   <= period_next;
            hpu_reg      <= hpu_next;
            kind_reg     <= kind_next;
            present_reg  <= present_next;
            timer_reg    <= timer_next;
            running_reg  <= running_next;
            phase_reg    <= phase_next;
            gate_reg     <= gate_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            level_reg    <= level_next;
            enable_reg   <= enable_next;
            delay_pl_reg <= delay_pl_next;
            pulse_pl_reg <= pulse_pl_next;
            protect_reg  <= protect_next;
            fan_reg      <= fan_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div) begin
            div_prod_reg <= DIV_PROD_W'(sum_reg) * DIV_PROD_W'(DIV_MUL);
        end
        if (cmd.scale) begin
            avg_reg <= scaling_on ? scale_prod[SCALE_SHIFT +: 8] : avg_raw;
        end
        if (cmd.level) begin
            lh_reg <= 15'(level_next) * 15'(hpu_reg);
        end
        if (cmd.pre) begin
            var_reg   <= 15'(lh_reg[14:8]) * 15'(PRELOAD_STEP);
            hp200_reg <= 15'(hpu_reg) * 15'(PRELOAD_STEP);
        end
        if (cmd.publish) begin
            gate_out_reg    <= gate_next;
            fan_out_reg     <= fan_next;
            protect_out_reg <= protect_next;
            enable_out_reg  <= enable_next;
            kind_out_reg    <= kind_next;
            present_out_reg <= present_next;
            level_out_reg   <= level_next;
        end
    end

    assign m_gate_drive       = gate_out_reg;
    assign m_fan_on           = fan_out_reg;
    assign m_overheat_protect = protect_out_reg;
    assign m_firing_enabled   = enable_out_reg;
    assign m_mains_kind       = kind_out_reg;
    assign m_mains_present    = present_out_reg;
    assign m_level            = level_out_reg;

endmodule

`default_nettype wire
